// ===== sv/ack_bitfield_retransmit_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the acknowledgement retransmit tracker
// Helpers for concurrent checks with a shared clock and reset.
// ----------------------------------------------------------------------------
`ifndef ACK_BITFIELD_RETRANSMIT_TRACKER_MACROS_SVH
`define ACK_BITFIELD_RETRANSMIT_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abrt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abrt: next-cycle check failed");

`endif

// ===== sv/abrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Acknowledgement retransmit tracker package
// Shared types, codes and fixed widths.
// ----------------------------------------------------------------------------
package abrt_pkg;

  localparam int unsigned SEQ_W   = 8;
  localparam int unsigned BITS_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [WAIT_W-1:0] RESEND_WAIT_RESET = 16'd80;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ACK    = 2'd1,
    OP_TICK   = 2'd2,
    OP_RETAG  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_STORED    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_ACKED     = 3'd2,
    KIND_RESEND    = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINAL,
    S_RETAG
  } state_t;

  typedef struct packed {
    logic ready;
    logic capture;
    logic step;
    logic store;
    logic clear;
    logic resend;
    logic finish;
    logic retag;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  op;
    logic hit;
    logic last_entry;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== sv/abrt_item_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one tracker request.
// ----------------------------------------------------------------------------
interface abrt_item_if;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [abrt_pkg::SEQ_W-1:0]    seq_num;
  logic [abrt_pkg::SEQ_W-1:0]    ack_ref;
  logic [abrt_pkg::BITS_W-1:0]   ack_bits;
  logic [abrt_pkg::TIME_W-1:0]   now_ms;
  logic [abrt_pkg::SLOT_W-1:0]   slot;

  modport source (
    output valid, operation, seq_num, ack_ref, ack_bits, now_ms, slot,
    input  ready
  );

  modport sink (
    input  valid, operation, seq_num, ack_ref, ack_bits, now_ms, slot,
    output ready
  );

endinterface

// ===== sv/abrt_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one tracker result.
// ----------------------------------------------------------------------------
interface abrt_result_if;

  logic                           valid;
  logic                           ready;
  logic [2:0]                     kind;
  logic [abrt_pkg::SLOT_W-1:0]    slot_out;
  logic [abrt_pkg::SEQ_W-1:0]     seq_out;
  logic [abrt_pkg::COUNT_W-1:0]   removed_count;
  logic                           last;

  modport source (
    output valid, kind, slot_out, seq_out, removed_count, last,
    input  ready
  );

  modport sink (
    input  valid, kind, slot_out, seq_out, removed_count, last,
    output ready
  );

endinterface

// ===== sv/abrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences the entry scan for each request and issues datapath commands.
// ----------------------------------------------------------------------------
module abrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  abrt_pkg::ctl_sts_t  sts,
  output abrt_pkg::ctl_cmd_t  cmd
);

  abrt_pkg::state_t state;
  abrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      abrt_pkg::S_IDLE: begin
        cmd.ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          if (sts.in_op == abrt_pkg::OP_RETAG) begin
            state_next = abrt_pkg::S_RETAG;
          end else begin
            state_next = abrt_pkg::S_READ;
          end
        end
      end
      abrt_pkg::S_READ: begin
        state_next = abrt_pkg::S_EVAL;
      end
      abrt_pkg::S_EVAL: begin
        case (sts.op)
          abrt_pkg::OP_INSERT: begin
            if (sts.hit) begin
              if (sts.out_free) begin
                cmd.store  = 1'b1;
                state_next = abrt_pkg::S_IDLE;
              end
            end else if (sts.last_entry) begin
              state_next = abrt_pkg::S_FINAL;
            end else begin
              cmd.step   = 1'b1;
              state_next = abrt_pkg::S_READ;
            end
          end
          abrt_pkg::OP_ACK: begin
            cmd.clear = sts.hit;
            if (sts.last_entry) begin
              state_next = abrt_pkg::S_FINAL;
            end else begin
              cmd.step   = 1'b1;
              state_next = abrt_pkg::S_READ;
            end
          end
          abrt_pkg::OP_TICK: begin
            if (!sts.hit || sts.out_free) begin
              cmd.resend = sts.hit;
              if (sts.last_entry) begin
                state_next = abrt_pkg::S_FINAL;
              end else begin
                cmd.step   = 1'b1;
                state_next = abrt_pkg::S_READ;
              end
            end
          end
          default: begin
            state_next = abrt_pkg::S_IDLE;
          end
        endcase
      end
      abrt_pkg::S_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = abrt_pkg::S_IDLE;
        end
      end
      abrt_pkg::S_RETAG: begin
        cmd.retag  = 1'b1;
        state_next = abrt_pkg::S_IDLE;
      end
      default: begin
        state_next = abrt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/abrt_datapath.sv =====
// ----------------------------------------------------------------------------
// Tracker datapath
// Entry table, scan index, match logic, resend timer and result register.
// ----------------------------------------------------------------------------
module abrt_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [abrt_pkg::WAIT_W-1:0]   cfg_wr_data,
  abrt_item_if.sink                     item,
  abrt_result_if.source                 result,
  input  abrt_pkg::ctl_cmd_t            cmd,
  output abrt_pkg::ctl_sts_t            sts
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [abrt_pkg::WAIT_W-1:0]  resend_wait_ms;
  logic [TABLE_DEPTH-1:0]       valid;
  logic [IW-1:0]                idx;
  logic [abrt_pkg::COUNT_W-1:0] count;

  abrt_pkg::op_t                cap_op;
  logic [abrt_pkg::SEQ_W-1:0]   cap_seq;
  logic [abrt_pkg::SEQ_W-1:0]   cap_ref;
  logic [abrt_pkg::BITS_W-1:0]  cap_bits;
  logic [abrt_pkg::TIME_W-1:0]  cap_now;
  logic [abrt_pkg::SLOT_W-1:0]  cap_slot;

  logic [abrt_pkg::SEQ_W-1:0]   mem_seq   [TABLE_DEPTH];
  logic [abrt_pkg::SEQ_W-1:0]   mem_tag   [TABLE_DEPTH];
  logic [abrt_pkg::TIME_W-1:0]  mem_timer [TABLE_DEPTH];
  logic [abrt_pkg::SEQ_W-1:0]   rd_seq;
  logic [abrt_pkg::SEQ_W-1:0]   rd_tag;
  logic [abrt_pkg::TIME_W-1:0]  rd_timer;

  logic [IW-1:0]                slot_idx;
  logic                         retag_ok;
  logic                         tag_we;
  logic [IW-1:0]                tag_addr;
  logic [abrt_pkg::SEQ_W-1:0]   distance;
  logic [3:0]                   bit_sel;
  logic                         ack_match;
  logic [abrt_pkg::TIME_W-1:0]  elapsed;
  logic                         due;
  logic                         hit;
  logic                         load;

  assign item.ready = cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_wait_ms <= abrt_pkg::RESEND_WAIT_RESET;
    end else if (cfg_wr_en) begin
      resend_wait_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op   <= abrt_pkg::op_t'(item.operation);
      cap_seq  <= item.seq_num;
      cap_ref  <= item.ack_ref;
      cap_bits <= item.ack_bits;
      cap_now  <= item.now_ms;
      cap_slot <= item.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.capture) begin
        count <= '0;
      end else if (cmd.clear) begin
        count <= count + 1'b1;
      end
    end
  end

  assign slot_idx = IW'(cap_slot);
  assign retag_ok = (32'(cap_slot) < 32'(TABLE_DEPTH)) && valid[slot_idx];
  assign tag_we   = cmd.store || (cmd.retag && retag_ok);
  assign tag_addr = cmd.retag ? slot_idx : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.store) begin
      valid[idx] <= 1'b1;
    end else if (cmd.clear) begin
      valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_seq[idx] <= cap_seq;
    end
    rd_seq <= mem_seq[idx];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      mem_tag[tag_addr] <= cap_seq;
    end
    rd_tag <= mem_tag[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.store || cmd.resend) begin
      mem_timer[idx] <= cap_now;
    end
    rd_timer <= mem_timer[idx];
  end

  // Flag bit 15 - d is the same as bit ~d over four bits.
  assign distance  = cap_ref - rd_tag;
  assign bit_sel   = ~distance[3:0];
  assign ack_match = (distance == '0) || ((distance[7:4] == 4'd0) && cap_bits[bit_sel]);
  assign elapsed   = cap_now - rd_timer;
  assign due       = elapsed >= {16'd0, resend_wait_ms};

  always_comb begin
    case (cap_op)
      abrt_pkg::OP_INSERT: hit = !valid[idx];
      abrt_pkg::OP_ACK:    hit = valid[idx] && ack_match;
      abrt_pkg::OP_TICK:   hit = valid[idx] && due;
      default:             hit = 1'b0;
    endcase
  end

  assign sts.in_op      = abrt_pkg::op_t'(item.operation);
  assign sts.op         = cap_op;
  assign sts.hit        = hit;
  assign sts.last_entry = (idx == IW'(TABLE_DEPTH - 1));
  assign sts.out_free   = !result.valid || result.ready;

  assign load = cmd.store || cmd.resend || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.slot_out      <= '0;
      result.seq_out       <= '0;
      result.removed_count <= '0;
      result.last          <= 1'b1;
      if (cmd.store) begin
        result.kind     <= abrt_pkg::KIND_STORED;
        result.slot_out <= abrt_pkg::SLOT_W'(idx);
      end else if (cmd.resend) begin
        result.kind     <= abrt_pkg::KIND_RESEND;
        result.slot_out <= abrt_pkg::SLOT_W'(idx);
        result.seq_out  <= rd_seq;
        result.last     <= 1'b0;
      end else begin
        case (cap_op)
          abrt_pkg::OP_INSERT: result.kind <= abrt_pkg::KIND_FULL;
          abrt_pkg::OP_ACK: begin
            result.kind          <= abrt_pkg::KIND_ACKED;
            result.removed_count <= count;
          end
          default: result.kind <= abrt_pkg::KIND_TICK_DONE;
        endcase
      end
    end
  end

endmodule

// ===== sv/ack_bitfield_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// Acknowledgement bitfield retransmit tracker
// Keeps unacknowledged packets in a table, removes acknowledged ones and
// requests resends when their timers run out.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// item      in   operation, seq_num, ack_ref, ack_bits, now_ms, slot
// result    out  kind, slot_out, seq_out, removed_count, last
// cfg_wr    in   resend_wait_ms (write only)
//
// Each entry visited is read at the scan index in S_READ, then evaluated and
// updated in S_EVAL. Ack and tick visit every entry, insert stops at the first
// free one; results wait for a free output. One request is in work at a time; a
// finished result may wait in the output register while the next request is
// taken. Reset clears the valid bits and sets the wait to 80 ms.
// ----------------------------------------------------------------------------
`include "ack_bitfield_retransmit_tracker_macros.svh"

module ack_bitfield_retransmit_tracker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [abrt_pkg::WAIT_W-1:0]   cfg_wr_data,
  abrt_item_if.sink                     item,
  abrt_result_if.source                 result
);

  abrt_pkg::ctl_cmd_t cmd;
  abrt_pkg::ctl_sts_t sts;
  logic               res_is_resend;
  logic               res_is_ack;
  logic               res_ack_clean;

  abrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  abrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .result      (result),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign res_is_resend = (result.kind == abrt_pkg::KIND_RESEND);
  assign res_is_ack    = (result.kind == abrt_pkg::KIND_ACKED);
  assign res_ack_clean = (result.slot_out == '0) && (result.seq_out == '0);

  `ABRT_ASSERT_SAME(a_last_by_kind, clk, rst, result.valid, result.last == !res_is_resend)
  `ABRT_ASSERT_NEXT(a_busy_after_take, clk, rst, item.valid && item.ready, !item.ready)
  `ABRT_ASSERT_SAME(a_ack_fields, clk, rst, result.valid && res_is_ack, res_ack_clean)

endmodule

// ===== tb/sv/tb_ack_bitfield_retransmit_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the acknowledgement bitfield retransmit tracker
// Sends insert, ack, tick and retag requests over the request channel. It
// starts with a table of directed requests, then runs three random phases with
// different resend waits and idling on each side. Every result is checked
// field by field against an in-bench copy of the table.
// ----------------------------------------------------------------------------
module tb_ack_bitfield_retransmit_tracker;
  import abrt_pkg::*;

  localparam int unsigned DEPTH            = 16;
  localparam int unsigned LIMIT_CYCLES     = 400000;
  localparam int unsigned SETTLE_CYCLES    = 2 * DEPTH + 8;
  localparam int unsigned RANDOM_PER_PHASE = 122;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned NUM_STEPS        = 17;

  typedef struct packed {
    op_t                op;
    logic [SEQ_W-1:0]   seq;
    logic [SEQ_W-1:0]   ack_ref;
    logic [BITS_W-1:0]  bits;
    logic [TIME_W-1:0]  now;
    logic [SLOT_W-1:0]  slot;
  } request_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [SEQ_W-1:0]    seq;
    logic [COUNT_W-1:0]  removed;
    logic                last;
  } result_t;

  typedef struct packed {
    request_t     req;
    int unsigned  reps;
    bit           typed;
    result_t      exp;
  } step_row_t;

  localparam result_t NO_RESULT = '{KIND_STORED, 4'd0, 8'h00, 5'd0, 1'b0};

  localparam step_row_t STEPS [NUM_STEPS] = '{
    '{'{OP_TICK,   8'h00, 8'h00, 16'h0000, 32'hFFFF_FFFF, 4'd0}, 1, 1'b1,
      '{KIND_TICK_DONE, 4'd0, 8'h00, 5'd0, 1'b1}},
    '{'{OP_INSERT, 8'h00, 8'h00, 16'h0000, 32'hFFFF_FFF0, 4'd0}, 1, 1'b1,
      '{KIND_STORED, 4'd0, 8'h00, 5'd0, 1'b1}},
    '{'{OP_INSERT, 8'hFF, 8'h00, 16'h0000, 32'hFFFF_FFF0, 4'd0}, 1, 1'b1,
      '{KIND_STORED, 4'd1, 8'h00, 5'd0, 1'b1}},
    '{'{OP_INSERT, 8'h80, 8'h00, 16'h0000, 32'h0000_0000, 4'd0}, 1, 1'b1,
      '{KIND_STORED, 4'd2, 8'h00, 5'd0, 1'b1}},
    '{'{OP_TICK,   8'h00, 8'h00, 16'h0000, 32'h0000_003F, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_TICK,   8'h00, 8'h00, 16'h0000, 32'h0000_0040, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_RETAG,  8'h10, 8'h00, 16'h0000, 32'h0000_0040, 4'd1}, 1, 1'b0, NO_RESULT},
    '{'{OP_RETAG,  8'h22, 8'h00, 16'h0000, 32'h0000_0040, 4'd15}, 1, 1'b0, NO_RESULT},
    '{'{OP_ACK,    8'h00, 8'h1F, 16'h0001, 32'h0000_0040, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_ACK,    8'h00, 8'h8F, 16'hFFFF, 32'h0000_0040, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_ACK,    8'h00, 8'h10, 16'hFFFF, 32'h0000_0040, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_INSERT, 8'h00, 8'h00, 16'h0000, 32'h0000_0064, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_INSERT, 8'h40, 8'h00, 16'h0000, 32'h0000_03E8, 4'd0}, 14, 1'b0, NO_RESULT},
    '{'{OP_INSERT, 8'h41, 8'h00, 16'h0000, 32'h0000_03E8, 4'd0}, 1, 1'b1,
      '{KIND_FULL, 4'd0, 8'h00, 5'd0, 1'b1}},
    '{'{OP_TICK,   8'h00, 8'h00, 16'h0000, 32'h0000_0438, 4'd0}, 1, 1'b0, NO_RESULT},
    '{'{OP_ACK,    8'h00, 8'h40, 16'h0000, 32'h0000_0438, 4'd0}, 1, 1'b1,
      '{KIND_ACKED, 4'd0, 8'h00, 5'd14, 1'b1}},
    '{'{OP_ACK,    8'h00, 8'h00, 16'h0000, 32'h0000_0438, 4'd0}, 1, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [WAIT_W-1:0] cfg_wr_data;

  abrt_item_if   req_ch ();
  abrt_result_if res_ch ();

  ack_bitfield_retransmit_tracker #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (req_ch),
    .result      (res_ch)
  );

  logic              tbl_valid [DEPTH];
  logic [SEQ_W-1:0]  tbl_seq   [DEPTH];
  logic [SEQ_W-1:0]  tbl_tag   [DEPTH];
  logic [TIME_W-1:0] tbl_start [DEPTH];
  logic [WAIT_W-1:0] wait_ms;

  result_t           awaited_results [$];
  int unsigned       mismatches;
  int unsigned       cycle_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  logic [SEQ_W-1:0]  next_seq;
  logic [TIME_W-1:0] clock_ms;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("** ack_bitfield_retransmit_tracker: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input result_t want,
                                 input result_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch (%s) at %0t: expected kind=%0d slot=%0d seq=%02h removed=%0d",
               what, $time, want.kind, want.slot, want.seq, want.removed);
      $display("  last=%0b, got kind=%0d slot=%0d seq=%02h removed=%0d last=%0b",
               want.last, seen.kind, seen.slot, seen.seq, seen.removed, seen.last);
    end
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.kind    = kind_t'(res_ch.kind);
      seen.slot    = res_ch.slot_out;
      seen.seq     = res_ch.seq_out;
      seen.removed = res_ch.removed_count;
      seen.last    = res_ch.last;
      if (awaited_results.size() == 0) begin
        report_mismatch("no result expected", NO_RESULT, seen);
      end else begin
        want = awaited_results.pop_front();
        if (seen !== want) begin
          report_mismatch("wrong field", want, seen);
        end
      end
    end
  end

  task automatic queue_result(input result_t res);
    awaited_results.insert(awaited_results.size(), res);
  endtask

  task automatic track_request(input request_t r);
    result_t          out;
    result_t          resend;
    logic [SEQ_W-1:0] distance;
    logic [TIME_W-1:0] elapsed;
    int unsigned      removed;
    bit               stored;
    stored  = 1'b0;
    removed = 0;
    out     = NO_RESULT;
    out.last = 1'b1;
    case (r.op)
      OP_INSERT: begin
        out.kind = KIND_FULL;
        for (int i = 0; i < DEPTH; i++) begin
          if (!stored && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_seq[i]   = r.seq;
            tbl_tag[i]   = r.seq;
            tbl_start[i] = r.now;
            out.kind     = KIND_STORED;
            out.slot     = SLOT_W'(i);
            stored       = 1'b1;
          end
        end
        queue_result(out);
      end
      OP_ACK: begin
        for (int i = 0; i < DEPTH; i++) begin
          distance = r.ack_ref - tbl_tag[i];
          if (tbl_valid[i] &&
              (distance == 0 || (distance < 16 && r.bits[BITS_W-1-distance]))) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        end
        out.kind    = KIND_ACKED;
        out.removed = COUNT_W'(removed);
        queue_result(out);
      end
      OP_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          elapsed = r.now - tbl_start[i];
          if (tbl_valid[i] && elapsed >= wait_ms) begin
            resend = '{KIND_RESEND, SLOT_W'(i), tbl_seq[i], 5'd0, 1'b0};
            queue_result(resend);
            tbl_start[i] = r.now;
          end
        end
        out.kind = KIND_TICK_DONE;
        queue_result(out);
      end
      default: begin
        if (tbl_valid[r.slot]) begin
          tbl_tag[r.slot] = r.seq;
        end
      end
    endcase
  endtask

  task automatic send_request(input request_t r, input bit typed, input result_t stated);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= r.op;
    req_ch.seq_num   <= r.seq;
    req_ch.ack_ref   <= r.ack_ref;
    req_ch.ack_bits  <= r.bits;
    req_ch.now_ms    <= r.now;
    req_ch.slot      <= r.slot;
    do @(posedge clk); while (!req_ch.ready);
    track_request(r);
    if (typed) begin
      void'(awaited_results.pop_back());
      queue_result(stated);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_resend_wait(input logic [WAIT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    wait_ms = value;
  endtask

  function automatic logic [TIME_W-1:0] tick_step();
    int unsigned span;
    span = wait_ms;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, span / 8 + 20);
      1: return (span >= 2) ? span - 2 + $urandom_range(0, 4) : $urandom_range(0, 4);
      2: return $urandom_range(0, 2 * span + 20);
      default: return 0;
    endcase
  endfunction

  task automatic random_request(output request_t r);
    int unsigned pick;
    int unsigned live [$];
    r.op      = op_t'($urandom_range(0, 3));
    r.seq     = SEQ_W'($urandom);
    r.ack_ref = SEQ_W'($urandom);
    r.bits    = BITS_W'($urandom);
    r.now     = $urandom;
    r.slot    = SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 10) begin
      r.now = clock_ms;
      if (pick < 45) begin
        r.op = OP_INSERT;
        r.seq = next_seq;
        next_seq++;
      end else if (pick < 68) begin
        r.op = OP_ACK;
        r.ack_ref = SEQ_W'(next_seq - 1 - $urandom_range(0, 20));
        if ($urandom_range(0, 1) == 0) r.bits = BITS_W'($urandom & $urandom & $urandom);
      end else if (pick < 88) begin
        r.op = OP_TICK;
        clock_ms = clock_ms + tick_step();
        r.now = clock_ms;
      end else begin
        r.op = OP_RETAG;
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) live.insert(live.size(), i);
        end
        if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
          r.slot = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
        end
        r.seq = next_seq;
        next_seq++;
      end
    end
  endtask

  initial begin
    request_t    r;
    int unsigned counted;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_INSERT;
    req_ch.seq_num     = '0;
    req_ch.ack_ref     = '0;
    req_ch.ack_bits    = '0;
    req_ch.now_ms      = '0;
    req_ch.slot        = '0;
    res_ch.ready       = 1'b0;
    mismatches         = 0;
    cycle_count        = 0;
    send_idle_pct      = 34;
    recv_idle_pct      = 51;
    next_seq           = SEQ_W'($urandom);
    clock_ms           = '0;
    wait_ms            = RESEND_WAIT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_seq[i]   = '0;
      tbl_tag[i]   = '0;
      tbl_start[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < NUM_STEPS; k++) begin
      repeat (STEPS[k].reps) send_request(STEPS[k].req, STEPS[k].typed, STEPS[k].exp);
    end
    settle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 51;
          write_resend_wait(16'd0);
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 34;
          write_resend_wait(16'hFFFF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_resend_wait(WAIT_W'($urandom_range(1, 300)));
        end
      endcase
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      counted  = 0;
      while (counted < RANDOM_PER_PHASE) begin
        random_request(r);
        if (!(r.op == OP_RETAG && !tbl_valid[r.slot])) counted++;
        send_request(r, 1'b0, NO_RESULT);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("** ack_bitfield_retransmit_tracker: PASSED **");
    end else begin
      $display("** ack_bitfield_retransmit_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/abrt_pkg.sv
sv/abrt_item_if.sv
sv/abrt_result_if.sv
sv/abrt_ctrl.sv
sv/abrt_datapath.sv
sv/ack_bitfield_retransmit_tracker.sv
tb/sv/tb_ack_bitfield_retransmit_tracker.sv
